>>> design/acmt_pkg.sv
// acmt_pkg: shared types and constants for the address-to-command map table.
// Used by acmt_cell and address_to_command_map_table; no dependencies.
package acmt_pkg;

  localparam int unsigned TableEntries = 8;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned AddrW        = 16;
  localparam int unsigned CountW       = 6;
  localparam int unsigned CmdW         = 8;

  localparam logic [CountW-1:0] MaxChunk   = CountW'(32);
  localparam logic [CmdW-1:0]   MapCmdBase = 8'h80;

  typedef enum logic {
    FuncLookup = 1'b0,
    FuncClear  = 1'b1
  } func_e;

  typedef struct packed {
    logic              func;
    logic [AddrW-1:0]  reg_addr;
    logic [CountW-1:0] byte_count;
    logic              is_read;
    logic              map_write_ok;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0]   command_code;
    logic              hit;
    logic [CmdW-1:0]   map_cmd;
    logic [AddrW-1:0]  entry_addr;
    logic [CountW-1:0] entry_count;
    logic              entry_write_mark;
    logic              error;
  } rsp_t;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [CountW-1:0] count;
    logic              wmark;
  } entry_t;

  // Search key broadcast to every cell
  typedef struct packed {
    logic   valid;
    logic   is_read;
    entry_t key;
  } lookup_t;

  // Priority chain passed from cell to cell
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } chain_t;

  // Per-cell write control
  typedef struct packed {
    logic   en;
    entry_t data;
  } cell_wr_t;

endpackage

>>> design/acmt_cell.sv
// acmt_cell: one table entry with its compare logic and priority chain link.
// Depends on acmt_pkg.
module acmt_cell
  import acmt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] idx_i,
  input  lookup_t         lookup_i,
  input  cell_wr_t        wr_i,
  input  chain_t          chain_i,
  output chain_t          chain_o
);

  entry_t entry_q, entry_d;
  logic   match;

  always_comb begin
    entry_d = wr_i.en ? wr_i.data : entry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  // Read needs equal count, write needs the write mark
  always_comb begin
    match = lookup_i.valid && (entry_q.addr == lookup_i.key.addr) &&
            (lookup_i.is_read ? (entry_q.count == lookup_i.key.count) : entry_q.wmark);
  end

  // Keep the first match found upstream
  always_comb begin
    chain_o.found = chain_i.found | match;
    chain_o.idx   = chain_i.found ? chain_i.idx : idx_i;
  end

endmodule

>>> design/address_to_command_map_table.sv
// address_to_command_map_table: top level, a row of acmt_cell entries plus
// the item register, victim pointer and result register. Depends on acmt_pkg, acmt_cell.
//
// Usage: an item transfers at a clock edge with start high and busy low.
// For each item, the accepting clock edge captures it in the item
// register, and during the following cycle busy is high while the key is
// broadcast to the row of eight cells, each comparing its own entry and
// passing a first-match flag and index down the chain. At the end of that
// cycle the table and the round-robin victim pointer update and the result
// is registered; it shows on rsp_o for exactly one cycle with rsp_valid_o
// high, and the receiver cannot stall it. A new item can be taken in that
// same cycle, but none while busy is high. A clear item zeroes all
// entries and returns an all-zero result; it leaves the victim pointer
// alone. Reset empties the table at once (no sweep).
module address_to_command_map_table
  import acmt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  logic            busy_q, busy_d;
  req_t            req_q;
  logic [IdxW-1:0] victim_q, victim_d;
  logic            rsp_valid_q, rsp_valid_d;
  rsp_t            rsp_q, rsp_d;

  logic              is_clear, is_miss;
  logic [CountW-1:0] count_clamped;
  entry_t            fresh;
  lookup_t           lookup;
  chain_t            chain [TableEntries+1];
  cell_wr_t          cell_wr [TableEntries];

  // Accept a transfer when idle; hold busy for the search cycle
  always_comb begin
    busy_d = busy_q ? 1'b0 : start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      victim_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      victim_q    <= victim_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  // Clamp the count before matching and storing
  always_comb begin
    count_clamped = (req_q.byte_count > MaxChunk) ? MaxChunk : req_q.byte_count;
    fresh.addr    = req_q.reg_addr;
    fresh.count   = count_clamped;
    fresh.wmark   = ~req_q.is_read;
    is_clear      = busy_q && (req_q.func == FuncClear);
    lookup.valid  = busy_q && (req_q.func == FuncLookup);
    lookup.is_read = req_q.is_read;
    lookup.key    = fresh;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    always_comb begin
      cell_wr[i].en   = is_clear || (is_miss && (victim_q == IdxW'(i)));
      cell_wr[i].data = (is_clear || !req_q.map_write_ok) ? '0 : fresh;
    end

    acmt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IdxW'(i)),
      .lookup_i (lookup),
      .wr_i     (cell_wr[i]),
      .chain_i  (chain[i]),
      .chain_o  (chain[i+1])
    );
  end

  assign is_miss = lookup.valid && !chain[TableEntries].found;

  // Advance the victim pointer on every miss, wrapping at the table size
  always_comb begin
    victim_d = victim_q;
    if (is_miss) begin
      victim_d = (victim_q == IdxW'(TableEntries - 1)) ? '0 : victim_q + 1'b1;
    end
  end

  // Build the result; clear and idle give all zero
  always_comb begin
    rsp_valid_d = busy_q;
    rsp_d       = '0;
    if (lookup.valid) begin
      if (chain[TableEntries].found) begin
        rsp_d.command_code = chain[TableEntries].idx;
        rsp_d.hit          = 1'b1;
      end else begin
        rsp_d.command_code     = victim_q;
        rsp_d.map_cmd          = MapCmdBase + CmdW'(victim_q);
        rsp_d.entry_addr       = fresh.addr;
        rsp_d.entry_count      = fresh.count;
        rsp_d.entry_write_mark = fresh.wmark;
        rsp_d.error            = ~req_q.map_write_ok;
      end
    end
  end

  assign busy        = busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_busy_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> rsp_valid_o && !busy)
    else $error("search cycle did not produce exactly one result");

  a_hit_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.hit |-> (rsp_o.map_cmd == '0) && !rsp_o.error)
    else $error("hit result carries miss fields");

  a_victim_moves_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_miss |=> $stable(victim_q))
    else $error("victim pointer moved without a miss");

endmodule
